// File: hdl/pcm_envelope_stage_setup_assert.svh
// ----------------------------------------------------------------------------
// pcm envelope stage setup: assertion macros
// concurrent checks clocked on clk, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PCM_ENVELOPE_STAGE_SETUP_ASSERT_SVH
`define PCM_ENVELOPE_STAGE_SETUP_ASSERT_SVH
`ifndef SYNTH
// check that is skipped while reset is asserted
`define PES_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("envelope stage setup check failed");
// check that also covers the reset cycles
`define PES_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("envelope stage setup reset check failed");
`else
`define PES_ASSERT(name, prop)
`define PES_ASSERT_RST(name, prop)
`endif
`endif

// File: hdl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// types, constants, stride tables and rate helpers of the envelope stage setup
// ----------------------------------------------------------------------------
package pes_pkg;

  // stage codes
  localparam logic [2:0] STG_ATTACK  = 3'd0;
  localparam logic [2:0] STG_DECAY1  = 3'd1;
  localparam logic [2:0] STG_DECAY2  = 3'd2;
  localparam logic [2:0] STG_OFF_A   = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;
  localparam logic [2:0] STG_OFF_B   = 3'd5;

  localparam logic [5:0] MAX_RATE     = 6'd63;
  localparam logic [5:0] DAMP_RATE    = 6'd56;
  localparam logic [5:0] PREVERB_RATE = 6'd5;
  localparam logic [5:0] MIN_RATE     = 6'd4;
  localparam logic [3:0] RATE_OFF     = 4'd0;
  localparam logic [3:0] RATE_FULL    = 4'd15;
  localparam logic [3:0] CORR_NO_KS   = 4'd15;

  localparam logic [31:0] FULL_SCALE  = 32'h8000_0000;
  localparam logic [31:0] PREVERB_LVL = 32'h1800_0000;

  // 2^31 / decay divisor per rate, zero below rate 4
  localparam logic [31:0] DECAY_Q [64] = '{
    32'd0,       32'd0,       32'd0,       32'd0,
    32'd546,     32'd682,     32'd819,     32'd955,
    32'd1092,    32'd1365,    32'd1638,    32'd1911,
    32'd2184,    32'd2730,    32'd3276,    32'd3822,
    32'd4369,    32'd5461,    32'd6553,    32'd7645,
    32'd8738,    32'd10922,   32'd13107,   32'd15291,
    32'd17476,   32'd21845,   32'd26214,   32'd30583,
    32'd34952,   32'd43690,   32'd52428,   32'd61167,
    32'd69905,   32'd87381,   32'd104857,  32'd122335,
    32'd139810,  32'd174762,  32'd209715,  32'd244671,
    32'd279620,  32'd349525,  32'd419430,  32'd489399,
    32'd559240,  32'd699050,  32'd838860,  32'd978798,
    32'd1118481, 32'd1398101, 32'd1677721, 32'd1957596,
    32'd2236962, 32'd2796202, 32'd3355443, 32'd3918765,
    32'd4473924, 32'd5592405, 32'd6710886, 32'd7837531,
    32'd8947848, 32'd8947848, 32'd8947848, 32'd8947848
  };

  // 2^31 / attack divisor per rate, before bit inversion
  localparam logic [31:0] ATTACK_Q [64] = '{
    32'd0,         32'd0,         32'd0,         32'd0,
    32'd7825,      32'd9781,      32'd11737,     32'd13694,
    32'd15650,     32'd19563,     32'd23475,     32'd27388,
    32'd31300,     32'd39126,     32'd46951,     32'd54777,
    32'd62601,     32'd78252,     32'd93903,     32'd109554,
    32'd125203,    32'd156510,    32'd187815,    32'd219108,
    32'd250406,    32'd313044,    32'd375631,    32'd438261,
    32'd500812,    32'd626088,    32'd751393,    32'd876523,
    32'd1001624,   32'd1252177,   32'd1502787,   32'd1753047,
    32'd2003249,   32'd2505815,   32'd3007680,   32'd3508960,
    32'd4006499,   32'd5017485,   32'd6015360,   32'd7017920,
    32'd8012998,   32'd10034970,  32'd12064514,  32'd14035840,
    32'd16025997,  32'd20069940,  32'd24129029,  32'd28256363,
    32'd32051994,  32'd40518559,  32'd48806446,  32'd56512727,
    32'd65075262,  32'd82595524,  32'd97612893,  32'd113025455,
    32'd126322567, 32'd126322567, 32'd126322567, 32'd0
  };

  typedef struct packed {
    logic [2:0]        stage;
    logic signed [3:0] octave;
    logic              freq_high_bit;
    logic [3:0]        rate_correction;
    logic [3:0]        attack_rate;
    logic [3:0]        decay1_rate;
    logic [3:0]        decay_level;
    logic [3:0]        decay2_rate;
    logic [3:0]        release_rate;
    logic              damping;
    logic              preverb_enable;
    logic [31:0]       current_volume;
  } item_t;

  typedef struct packed {
    logic [2:0]  stage_used;
    logic [31:0] volume_step;
    logic [31:0] volume_limit;
    logic        load_volume;
    logic [31:0] new_volume;
    logic        stop_playing;
    logic        set_preverb;
  } result_t;

  typedef struct packed {
    logic [5:0] rate;
    logic       preverb;
  } rate_sel_t;

  // key-scaled rate, clamped to 0..63
  function automatic logic [5:0] eff_rate(logic [3:0] setting, logic [3:0] octave,
                                          logic fhb, logic [3:0] corr);
    logic [7:0] t;
    logic [7:0] base;
    base = {2'd0, setting, 2'd0};
    t = {{4{octave[3]}}, octave} + {4'd0, corr};
    t = {t[6:0], 1'b0} + {7'd0, fhb} + base;
    if (corr == CORR_NO_KS) t = base;
    if (setting == RATE_OFF) return 6'd0;
    if (setting == RATE_FULL) return MAX_RATE;
    if (t[7]) return 6'd0;
    if (t > 8'd63) return MAX_RATE;
    return t[5:0];
  endfunction

  // decay-type rate with damping and preverb overrides
  function automatic rate_sel_t decay_sel(logic [3:0] setting, item_t it, logic [31:0] vol);
    rate_sel_t s;
    s.preverb = 1'b0;
    if (it.damping) begin
      s.rate = DAMP_RATE;
    end else if (it.preverb_enable && (vol > PREVERB_LVL)) begin
      s.rate    = PREVERB_RATE;
      s.preverb = 1'b1;
    end else begin
      s.rate = eff_rate(setting, it.octave, it.freq_high_bit, it.rate_correction);
    end
    return s;
  endfunction

endpackage

// File: hdl/pes_calc.sv
// ----------------------------------------------------------------------------
// pes_calc
// combinational stage resolution, rate selection and stride lookup
// ----------------------------------------------------------------------------
module pes_calc (
  input  pes_pkg::item_t   item,
  output pes_pkg::result_t res
);

  logic [5:0]         atk_rate;
  logic               fell;
  logic [2:0]         stg_mid;
  logic [2:0]         stg_used;
  logic [3:0]         dec_setting;
  logic [31:0]        vol_seen;
  pes_pkg::rate_sel_t dsel;
  logic [31:0]        dstep;
  logic               from_attack;

  always_comb begin
    atk_rate = pes_pkg::eff_rate(item.attack_rate, item.octave, item.freq_high_bit,
                                 item.rate_correction);
    from_attack = (item.stage == pes_pkg::STG_ATTACK);
    // attack at full rate jumps straight into decay 1
    fell     = from_attack && (atk_rate == pes_pkg::MAX_RATE);
    stg_mid  = fell ? pes_pkg::STG_DECAY1 : item.stage;
    // zero decay level skips decay 1
    stg_used = ((stg_mid == pes_pkg::STG_DECAY1) && (item.decay_level == 4'd0))
               ? pes_pkg::STG_DECAY2 : stg_mid;

    case (stg_used)
      pes_pkg::STG_DECAY1: dec_setting = item.decay1_rate;
      pes_pkg::STG_DECAY2: dec_setting = item.decay2_rate;
      default:             dec_setting = item.release_rate;
    endcase

    vol_seen = fell ? 32'd0 : item.current_volume;
    dsel     = pes_pkg::decay_sel(dec_setting, item, vol_seen);
    dstep    = pes_pkg::DECAY_Q[dsel.rate];

    res              = '0;
    res.stage_used   = stg_used;
    res.load_volume  = from_attack;
    case (stg_used)
      pes_pkg::STG_ATTACK: begin
        res.new_volume   = pes_pkg::FULL_SCALE;
        res.volume_limit = pes_pkg::FULL_SCALE - 32'd1;
        res.volume_step  = (atk_rate >= pes_pkg::MIN_RATE)
                           ? ~pes_pkg::ATTACK_Q[atk_rate] : 32'd0;
      end
      pes_pkg::STG_DECAY1: begin
        res.volume_step  = dstep;
        res.volume_limit = {2'd0, item.decay_level, 26'd0};
        res.set_preverb  = dsel.preverb;
      end
      pes_pkg::STG_DECAY2, pes_pkg::STG_RELEASE: begin
        res.volume_step  = dstep;
        res.volume_limit = pes_pkg::FULL_SCALE;
        res.set_preverb  = dsel.preverb;
      end
      pes_pkg::STG_OFF_A, pes_pkg::STG_OFF_B: begin
        res.load_volume  = 1'b1;
        res.new_volume   = pes_pkg::FULL_SCALE;
        res.stop_playing = 1'b1;
      end
      default: begin
        res.load_volume = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/pcm_envelope_stage_setup.sv
// ----------------------------------------------------------------------------
// pcm_envelope_stage_setup
// envelope stage entry: stride, limit, volume reload and flags for one channel
// ----------------------------------------------------------------------------
// usage
//   in_*  : one channel's stage and rate settings per transfer (valid/ready)
//   out_* : one result per input transfer, in order (valid/ready)
//   no configuration registers, no state carried between items
// latency and throughput
//   out_valid rises at the edge after the input transfer edge if out_ready
//   is high: an input register, then the stage/rate logic and table lookups
//   feeding the result register; the result transfer can follow at the next
//   edge; one item per cycle while out_ready stays high; both stages advance
//   whenever the stage ahead is empty or being emptied in the same cycle
// reset
//   synchronous, active low; clears both valid flags, payload registers keep
//   whatever they hold
// stall behavior
//   with out_ready low the result holds on out_*, the input register still
//   takes one more item if it is empty, then in_ready drops until the
//   receiver takes a transfer; no item is lost or repeated
// ----------------------------------------------------------------------------
`include "pcm_envelope_stage_setup_assert.svh"

module pcm_envelope_stage_setup (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_stage,
  input  logic signed [3:0] in_octave,
  input  logic              in_freq_high_bit,
  input  logic [3:0]        in_rate_correction,
  input  logic [3:0]        in_attack_rate,
  input  logic [3:0]        in_decay1_rate,
  input  logic [3:0]        in_decay_level,
  input  logic [3:0]        in_decay2_rate,
  input  logic [3:0]        in_release_rate,
  input  logic              in_damping,
  input  logic              in_preverb_enable,
  input  logic [31:0]       in_current_volume,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_stage_used,
  output logic [31:0]       out_volume_step,
  output logic [31:0]       out_volume_limit,
  output logic              out_load_volume,
  output logic [31:0]       out_new_volume,
  output logic              out_stop_playing,
  output logic              out_set_preverb
);

  // input register stage
  logic             s1_valid_r;
  pes_pkg::item_t   s1_item_r;
  pes_pkg::item_t   in_item;

  // result register stage
  logic             res_valid_r;
  pes_pkg::result_t res_r;
  pes_pkg::result_t res_nxt;

  logic             out_adv;
  logic             s1_adv;

  // terms used by the checks below
  logic             off_reload_ok;
  logic             preverb_step_ok;

  // gather the input ports into one item
  always_comb begin
    in_item.stage           = in_stage;
    in_item.octave          = in_octave;
    in_item.freq_high_bit   = in_freq_high_bit;
    in_item.rate_correction = in_rate_correction;
    in_item.attack_rate     = in_attack_rate;
    in_item.decay1_rate     = in_decay1_rate;
    in_item.decay_level     = in_decay_level;
    in_item.decay2_rate     = in_decay2_rate;
    in_item.release_rate    = in_release_rate;
    in_item.damping         = in_damping;
    in_item.preverb_enable  = in_preverb_enable;
    in_item.current_volume  = in_current_volume;
  end

  // a stage may load when it is empty or its content moves on this cycle
  assign out_adv  = !res_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // stage resolution and stride lookup
  pes_calc u_calc (
    .item (s1_item_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_adv) begin
      res_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_stage_used   = res_r.stage_used;
  assign out_volume_step  = res_r.volume_step;
  assign out_volume_limit = res_r.volume_limit;
  assign out_load_volume  = res_r.load_volume;
  assign out_new_volume   = res_r.new_volume;
  assign out_stop_playing = res_r.stop_playing;
  assign out_set_preverb  = res_r.set_preverb;

  assign off_reload_ok   = out_load_volume && (out_new_volume == pes_pkg::FULL_SCALE);
  assign preverb_step_ok = (out_volume_step == pes_pkg::DECAY_Q[pes_pkg::PREVERB_RATE]);

  // reset empties the result stage
  `PES_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid)
  // no transfer is taken while both stages are full and the receiver stalls
  `PES_ASSERT(a_no_overrun, !(s1_valid_r && res_valid_r && !out_ready && in_ready))
  // off stages always reload a silent volume
  `PES_ASSERT(a_off_reload, (out_valid && out_stop_playing) |-> off_reload_ok)
  // preverb always runs at its fixed rate
  `PES_ASSERT(a_preverb_step, (out_valid && out_set_preverb) |-> preverb_step_ok)

endmodule

// File: test/pcm_envelope_stage_setup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_envelope_stage_setup_checker
// watches the input and output transfers, predicts each item's stage setup and compares it
// ----------------------------------------------------------------------------
module pcm_envelope_stage_setup_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_stage,
  input  logic signed [3:0] in_octave,
  input  logic              in_freq_high_bit,
  input  logic [3:0]        in_rate_correction,
  input  logic [3:0]        in_attack_rate,
  input  logic [3:0]        in_decay1_rate,
  input  logic [3:0]        in_decay_level,
  input  logic [3:0]        in_decay2_rate,
  input  logic [3:0]        in_release_rate,
  input  logic              in_damping,
  input  logic              in_preverb_enable,
  input  logic [31:0]       in_current_volume,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_stage_used,
  input  logic [31:0]       out_volume_step,
  input  logic [31:0]       out_volume_limit,
  input  logic              out_load_volume,
  input  logic [31:0]       out_new_volume,
  input  logic              out_stop_playing,
  input  logic              out_set_preverb,
  output int                mismatch_count,
  output int                pending_count
);

  // per-rate divisors of the full-scale volume
  localparam logic [31:0] DECAY_DIV [64] = '{
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h003C0000, 32'h00300000, 32'h00280000, 32'h00224924,
    32'h001E0000, 32'h00180000, 32'h00140000, 32'h00112492,
    32'h000F0000, 32'h000C0000, 32'h000A0000, 32'h00089249,
    32'h00078000, 32'h00060000, 32'h00050000, 32'h00044924,
    32'h0003C000, 32'h00030000, 32'h00028000, 32'h00022492,
    32'h0001E000, 32'h00018000, 32'h00014000, 32'h00011249,
    32'h0000F000, 32'h0000C000, 32'h0000A000, 32'h00008924,
    32'h00007800, 32'h00006000, 32'h00005000, 32'h00004492,
    32'h00003C00, 32'h00003000, 32'h00002800, 32'h00002249,
    32'h00001E00, 32'h00001800, 32'h00001400, 32'h00001124,
    32'h00000F00, 32'h00000C00, 32'h00000A00, 32'h00000892,
    32'h00000780, 32'h00000600, 32'h00000500, 32'h00000449,
    32'h000003C0, 32'h00000300, 32'h00000280, 32'h00000224,
    32'h000001E0, 32'h00000180, 32'h00000140, 32'h00000112,
    32'h000000F0, 32'h000000F0, 32'h000000F0, 32'h000000F0
  };

  localparam logic [31:0] ATTACK_DIV [64] = '{
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00043000, 32'h00035999, 32'h0002CAAA, 32'h00026492,
    32'h00021800, 32'h0001ACCC, 32'h00016555, 32'h00013249,
    32'h00010C00, 32'h0000D666, 32'h0000B2AA, 32'h00009924,
    32'h00008600, 32'h00006B33, 32'h00005955, 32'h00004C92,
    32'h00004300, 32'h00003599, 32'h00002CAA, 32'h00002649,
    32'h00002180, 32'h00001ACC, 32'h00001655, 32'h00001324,
    32'h000010C0, 32'h00000D66, 32'h00000B2A, 32'h00000992,
    32'h00000860, 32'h000006B3, 32'h00000595, 32'h000004C9,
    32'h00000430, 32'h00000359, 32'h000002CA, 32'h00000264,
    32'h00000218, 32'h000001AC, 32'h00000165, 32'h00000132,
    32'h0000010C, 32'h000000D6, 32'h000000B2, 32'h00000099,
    32'h00000086, 32'h0000006B, 32'h00000059, 32'h0000004C,
    32'h00000043, 32'h00000035, 32'h0000002C, 32'h00000026,
    32'h00000021, 32'h0000001A, 32'h00000016, 32'h00000013,
    32'h00000011, 32'h00000011, 32'h00000011, 32'h00000000
  };

  pes_pkg::result_t setups_due [$];
  pes_pkg::result_t want;
  pes_pkg::item_t   seen;

  // key-scaled rate, clamped to 0..63
  function automatic int scaled_rate(logic [3:0] setting, pes_pkg::item_t it);
    int oct;
    int r;
    oct = it.octave[3] ? int'(it.octave[2:0]) - 8 : int'(it.octave[2:0]);
    if (setting == pes_pkg::RATE_OFF) return 0;
    if (setting == pes_pkg::RATE_FULL) return int'(pes_pkg::MAX_RATE);
    r = int'(setting) * 4;
    if (it.rate_correction != pes_pkg::CORR_NO_KS)
      r = r + (oct + int'(it.rate_correction)) * 2 + int'(it.freq_high_bit);
    if (r < 0) return 0;
    if (r > int'(pes_pkg::MAX_RATE)) return int'(pes_pkg::MAX_RATE);
    return r;
  endfunction

  // decay-type stride, damping and preverb take precedence over the setting
  function automatic logic [31:0] decay_stride(logic [3:0] setting, pes_pkg::item_t it,
                                               logic [31:0] vol, inout logic pre);
    int r;
    if (it.damping) begin
      r = int'(pes_pkg::DAMP_RATE);
    end else if (it.preverb_enable && vol > pes_pkg::PREVERB_LVL) begin
      pre = 1'b1;
      r = int'(pes_pkg::PREVERB_RATE);
    end else begin
      r = scaled_rate(setting, it);
    end
    if (r < int'(pes_pkg::MIN_RATE)) return 32'd0;
    return pes_pkg::FULL_SCALE / DECAY_DIV[r];
  endfunction

  function automatic pes_pkg::result_t envelope_setup_of(pes_pkg::item_t it);
    pes_pkg::result_t res;
    logic [2:0]       stg;
    logic [31:0]      vol;
    logic             pre;
    int               r;
    res = '0;
    stg = it.stage;
    vol = it.current_volume;
    pre = 1'b0;
    if (stg == pes_pkg::STG_ATTACK) begin
      r = scaled_rate(it.attack_rate, it);
      res.load_volume  = 1'b1;
      res.new_volume   = pes_pkg::FULL_SCALE;
      res.volume_limit = pes_pkg::FULL_SCALE - 32'd1;
      if (r == int'(pes_pkg::MAX_RATE)) begin
        // instant attack: start at zero attenuation and go on as decay 1
        res.new_volume = 32'd0;
        vol = 32'd0;
        stg = pes_pkg::STG_DECAY1;
      end else if (r >= int'(pes_pkg::MIN_RATE)) begin
        res.volume_step = ~(pes_pkg::FULL_SCALE / ATTACK_DIV[r]);
      end
    end
    if (stg == pes_pkg::STG_DECAY1) begin
      if (it.decay_level != 4'd0) begin
        res.volume_step  = decay_stride(it.decay1_rate, it, vol, pre);
        res.volume_limit = {2'b00, it.decay_level, 26'd0};
      end else begin
        stg = pes_pkg::STG_DECAY2;
      end
    end
    case (stg)
      pes_pkg::STG_DECAY2: begin
        res.volume_step  = decay_stride(it.decay2_rate, it, vol, pre);
        res.volume_limit = pes_pkg::FULL_SCALE;
      end
      pes_pkg::STG_OFF_A, pes_pkg::STG_OFF_B: begin
        res.load_volume  = 1'b1;
        res.new_volume   = pes_pkg::FULL_SCALE;
        res.volume_step  = 32'd0;
        res.volume_limit = 32'd0;
        res.stop_playing = 1'b1;
      end
      pes_pkg::STG_RELEASE: begin
        res.volume_step  = decay_stride(it.release_rate, it, vol, pre);
        res.volume_limit = pes_pkg::FULL_SCALE;
      end
      default: ;
    endcase
    res.stage_used  = stg;
    res.set_preverb = pre;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      setups_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        seen.stage           = in_stage;
        seen.octave          = in_octave;
        seen.freq_high_bit   = in_freq_high_bit;
        seen.rate_correction = in_rate_correction;
        seen.attack_rate     = in_attack_rate;
        seen.decay1_rate     = in_decay1_rate;
        seen.decay_level     = in_decay_level;
        seen.decay2_rate     = in_decay2_rate;
        seen.release_rate    = in_release_rate;
        seen.damping         = in_damping;
        seen.preverb_enable  = in_preverb_enable;
        seen.current_volume  = in_current_volume;
        setups_due.push_back(envelope_setup_of(seen));
      end
      if (out_valid && out_ready) begin
        if (setups_due.size() == 0) begin
          $error("result transfer with no setup outstanding");
          mismatch_count++;
        end else begin
          want = setups_due.pop_front();
          check_field("stage_used", {29'd0, want.stage_used}, {29'd0, out_stage_used});
          check_field("volume_step", want.volume_step, out_volume_step);
          check_field("volume_limit", want.volume_limit, out_volume_limit);
          check_field("load_volume", {31'd0, want.load_volume}, {31'd0, out_load_volume});
          check_field("new_volume", want.new_volume, out_new_volume);
          check_field("stop_playing", {31'd0, want.stop_playing},
                      {31'd0, out_stop_playing});
          check_field("set_preverb", {31'd0, want.set_preverb}, {31'd0, out_set_preverb});
        end
      end
    end
    pending_count = setups_due.size();
  end

endmodule

// File: test/pcm_envelope_stage_setup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_envelope_stage_setup_tb
// drives channel setups into the stage setup block with random gaps on both
// sides; a separate checker predicts every result and compares it in order
// ----------------------------------------------------------------------------
module pcm_envelope_stage_setup_tb;

  // stage codes the block does not use, results must be zero apart from the stage code
  localparam logic [2:0] STG_SPARE_A = 3'd6;
  localparam logic [2:0] STG_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 1628;
  localparam int HOLD_AT      = 400;   // transfers sent before the long stall
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_stage;
  logic signed [3:0] in_octave;
  logic              in_freq_high_bit;
  logic [3:0]        in_rate_correction;
  logic [3:0]        in_attack_rate;
  logic [3:0]        in_decay1_rate;
  logic [3:0]        in_decay_level;
  logic [3:0]        in_decay2_rate;
  logic [3:0]        in_release_rate;
  logic              in_damping;
  logic              in_preverb_enable;
  logic [31:0]       in_current_volume;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_stage_used;
  logic [31:0]       out_volume_step;
  logic [31:0]       out_volume_limit;
  logic              out_load_volume;
  logic [31:0]       out_new_volume;
  logic              out_stop_playing;
  logic              out_set_preverb;
  int                mismatch_count;
  int                pending_count;

  int   items_sent;   // accepted input transfers so far
  logic in_taken;     // input transfer seen at the last rising edge

  pcm_envelope_stage_setup dut (.*);

  pcm_envelope_stage_setup_checker chk (.*);

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("pcm_envelope_stage_setup verification failed");
    $finish;
  end

  // handshake sampled at the rising edge, read by the sender at the falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // every few hundred transfers the sender stops idling and the receiver draws no new stalls
  function automatic bit steady_phase();
    return ((items_sent / 128) % 4) == 3;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // rate setting with the off and full codes favored
  function automatic logic [3:0] rate_pick();
    logic [31:0] rnd;
    rnd = $urandom_range(0, 99);
    if (rnd < 15) return pes_pkg::RATE_OFF;
    if (rnd < 30) return pes_pkg::RATE_FULL;
    rnd = $urandom;
    return rnd[3:0];
  endfunction

  function automatic pes_pkg::item_t random_setting();
    pes_pkg::item_t it;
    logic [31:0]    rnd;
    int             p;
    p = $urandom_range(0, 99);
    rnd = (p < 4) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    it.stage = rnd[2:0];
    rnd = $urandom;
    it.octave          = rnd[3:0];
    it.freq_high_bit   = rnd[4];
    it.damping         = ($urandom_range(0, 99) < 15);
    it.preverb_enable  = rnd[5];
    it.rate_correction = ($urandom_range(0, 99) < 25) ? pes_pkg::CORR_NO_KS : rnd[11:8];
    it.decay_level     = ($urandom_range(0, 99) < 20) ? 4'd0 : rnd[15:12];
    it.attack_rate     = rate_pick();
    it.decay1_rate     = rate_pick();
    it.decay2_rate     = rate_pick();
    it.release_rate    = rate_pick();
    // volume around the preverb threshold, at the ends, or anywhere below full
    case ($urandom_range(0, 7))
      0: it.current_volume = 32'd0;
      1: it.current_volume = pes_pkg::FULL_SCALE;
      2: it.current_volume = pes_pkg::PREVERB_LVL;
      3: it.current_volume = pes_pkg::PREVERB_LVL + 32'd1;
      4: it.current_volume = pes_pkg::PREVERB_LVL - 32'd1;
      5: it.current_volume = pes_pkg::PREVERB_LVL + ($urandom & 32'h07FF_FFFF);
      default: it.current_volume = $urandom & 32'h7FFF_FFFF;
    endcase
    return it;
  endfunction

  // directed setup, the same rate used for all four rate settings
  function automatic pes_pkg::item_t make_item(logic [2:0] stg, logic [3:0] oct,
                                               logic fhb, logic [3:0] corr,
                                               logic [3:0] rate, logic [3:0] dl,
                                               logic damp, logic pre,
                                               logic [31:0] vol);
    pes_pkg::item_t it;
    it.stage           = stg;
    it.octave          = oct;
    it.freq_high_bit   = fhb;
    it.rate_correction = corr;
    it.attack_rate     = rate;
    it.decay1_rate     = rate;
    it.decay_level     = dl;
    it.decay2_rate     = rate;
    it.release_rate    = rate;
    it.damping         = damp;
    it.preverb_enable  = pre;
    it.current_volume  = vol;
    return it;
  endfunction

  // one input transfer: optional idle, then hold valid until accepted;
  // called and returning at a falling edge
  task automatic send_setup(pes_pkg::item_t it);
    int gap;
    gap = steady_phase() ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_stage           = it.stage;
    in_octave          = it.octave;
    in_freq_high_bit   = it.freq_high_bit;
    in_rate_correction = it.rate_correction;
    in_attack_rate     = it.attack_rate;
    in_decay1_rate     = it.decay1_rate;
    in_decay_level     = it.decay_level;
    in_decay2_rate     = it.decay2_rate;
    in_release_rate    = it.release_rate;
    in_damping         = it.damping;
    in_preverb_enable  = it.preverb_enable;
    in_current_volume  = it.current_volume;
    in_valid           = 1'b1;
    // the transfer edge shows up in in_taken by the following falling edge
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    items_sent++;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 1'b0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && items_sent >= HOLD_AT) begin
        // sender keeps offering, so in_ready has to drop during this stretch
        held_off  = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else if (steady_phase()) begin
        out_ready = 1'b1;
      end else begin
        stall_left = idle_len();
        if (stall_left > 0) begin
          out_ready  = 1'b0;
          stall_left = stall_left - 1;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    items_sent         = 0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_stage           = pes_pkg::STG_ATTACK;
    in_octave          = 4'd0;
    in_freq_high_bit   = 1'b0;
    in_rate_correction = 4'd0;
    in_attack_rate     = 4'd0;
    in_decay1_rate     = 4'd0;
    in_decay_level     = 4'd0;
    in_decay2_rate     = 4'd0;
    in_release_rate    = 4'd0;
    in_damping         = 1'b0;
    in_preverb_enable  = 1'b0;
    in_current_volume  = 32'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // attack: rate off, instant attack into decay 1 (preverb sees volume zero)
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'd0, 1'b0, 4'd0, pes_pkg::RATE_OFF,
                         4'd5, 1'b0, 1'b0, 32'd0));
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'd0, 1'b0, 4'd0, pes_pkg::RATE_FULL,
                         4'd7, 1'b0, 1'b1, 32'h7000_0000));
    // instant attack with zero decay level lands in decay 2
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'd3, 1'b1, 4'd4, pes_pkg::RATE_FULL,
                         4'd0, 1'b0, 1'b0, pes_pkg::FULL_SCALE));
    // key scaling clamps high (falls through) and low (no stride)
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'b0111, 1'b1, 4'd14, 4'd14, 4'd9, 1'b0,
                         1'b0, 32'd1));
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'b1000, 1'b0, 4'd0, 4'd1, 4'd9, 1'b0,
                         1'b0, 32'd0));
    // lowest rate with a stride, correction that disables key scaling, rate 61
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'd0, 1'b0, 4'd0, 4'd1, 4'd9, 1'b0, 1'b0,
                         32'd0));
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'b1000, 1'b1, pes_pkg::CORR_NO_KS, 4'd3,
                         4'd9, 1'b0, 1'b0, 32'd0));
    send_setup(make_item(pes_pkg::STG_ATTACK, 4'd0, 1'b1, 4'd2, 4'd14, 4'd9, 1'b0, 1'b0,
                         32'd0));
    // decay 1: damping, preverb just over, exactly at the threshold
    send_setup(make_item(pes_pkg::STG_DECAY1, 4'd2, 1'b0, 4'd3, 4'd6, 4'd4, 1'b1, 1'b1,
                         pes_pkg::FULL_SCALE));
    send_setup(make_item(pes_pkg::STG_DECAY1, 4'd2, 1'b0, 4'd3, 4'd6, 4'd4, 1'b0, 1'b1,
                         pes_pkg::PREVERB_LVL + 32'd1));
    send_setup(make_item(pes_pkg::STG_DECAY1, 4'd2, 1'b0, 4'd3, 4'd6, 4'd4, 1'b0, 1'b1,
                         pes_pkg::PREVERB_LVL));
    // zero decay level skips to decay 2, then the top decay level
    send_setup(make_item(pes_pkg::STG_DECAY1, 4'd1, 1'b1, 4'd5, 4'd8, 4'd0, 1'b0, 1'b1,
                         pes_pkg::FULL_SCALE));
    send_setup(make_item(pes_pkg::STG_DECAY1, 4'd1, 1'b1, 4'd5, 4'd8, 4'd15, 1'b0, 1'b0,
                         32'h0000_FFFF));
    // decay 2 at full rate and below the minimum rate
    send_setup(make_item(pes_pkg::STG_DECAY2, 4'd0, 1'b0, 4'd0, pes_pkg::RATE_FULL,
                         4'd3, 1'b0, 1'b0, 32'd0));
    send_setup(make_item(pes_pkg::STG_DECAY2, 4'b1111, 1'b1, 4'd0, 4'd1, 4'd3, 1'b0,
                         1'b0, 32'd0));
    // release: plain, damped, key scaling at its highest
    send_setup(make_item(pes_pkg::STG_RELEASE, 4'd5, 1'b0, pes_pkg::CORR_NO_KS, 4'd7,
                         4'd3, 1'b0, 1'b0, 32'h0F0F_0F0F));
    send_setup(make_item(pes_pkg::STG_RELEASE, 4'd5, 1'b0, 4'd1, 4'd7, 4'd3, 1'b1, 1'b0,
                         32'h2000_0000));
    send_setup(make_item(pes_pkg::STG_RELEASE, 4'b0111, 1'b1, 4'd14, pes_pkg::RATE_FULL,
                         4'd15, 1'b0, 1'b1, 32'h7FFF_FFFF));
    // off stages and the unused codes
    send_setup(make_item(pes_pkg::STG_OFF_A, 4'd2, 1'b1, 4'd6, 4'd9, 4'd2, 1'b1, 1'b1,
                         32'h1234_5678));
    send_setup(make_item(pes_pkg::STG_OFF_B, 4'd2, 1'b1, 4'd6, 4'd9, 4'd2, 1'b0, 1'b1,
                         pes_pkg::FULL_SCALE));
    send_setup(make_item(STG_SPARE_A, 4'b1111, 1'b1, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1,
                         pes_pkg::FULL_SCALE));
    send_setup(make_item(STG_SPARE_B, 4'b1000, 1'b0, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0,
                         32'd0));

    for (n = 0; n < RANDOM_ITEMS; n++)
      send_setup(random_setting());
    in_valid = 1'b0;

    // drain, then a few quiet cycles for any stray result transfer
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_count == 0)
      $display("pcm_envelope_stage_setup verification clean");
    else
      $display("pcm_envelope_stage_setup verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pes_pkg.sv
hdl/pes_calc.sv
hdl/pcm_envelope_stage_setup.sv
test/pcm_envelope_stage_setup_checker.sv
test/pcm_envelope_stage_setup_tb.sv
